// ===== design/sepq_pkg.sv =====
// Shared types and codes for the sorted event priority queue.
package sepq_pkg;

  // Codes of the input action field.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Codes of the result status field.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cycle command that the top level broadcasts to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== design/sepq_in_if.sv =====
// Input channel: push or pop command with the event payload.
interface sepq_in_if #(
  parameter int TIME_BITS   = 16,
  parameter int PERSON_BITS = 14
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [TIME_BITS-1:0]   ev_time;
  logic [PERSON_BITS-1:0] person;
  logic                   event_kind;

  modport source (output valid, action, ev_time, person, event_kind, input ready);
  modport sink   (input valid, action, ev_time, person, event_kind, output ready);
endinterface

// ===== design/sepq_out_if.sv =====
// Output channel: status, new head entry and occupancy for every item.
interface sepq_out_if #(
  parameter int TIME_BITS   = 16,
  parameter int PERSON_BITS = 14,
  parameter int CNT_BITS    = 7
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic                   is_empty;
  logic [TIME_BITS-1:0]   head_time;
  logic [PERSON_BITS-1:0] head_person;
  logic                   head_kind;
  logic [CNT_BITS-1:0]    occupancy;

  modport source (output valid, status, is_empty, head_time, head_person, head_kind,
                  occupancy, input ready);
  modport sink   (input valid, status, is_empty, head_time, head_person, head_kind,
                  occupancy, output ready);
endinterface

// ===== design/sepq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts to or from its neighbors.
module sepq_cell #(
  parameter int IDX         = 0,
  parameter int TIME_BITS   = 16,
  parameter int PERSON_BITS = 14,
  parameter int CNT_BITS    = 7
) (
  input  logic                   clk_i,
  input  sepq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_BITS-1:0]    count_i,
  input  logic [TIME_BITS-1:0]   new_time_i,
  input  logic [PERSON_BITS-1:0] new_person_i,
  input  logic                   new_kind_i,
  input  logic                   prev_ge_i,
  input  logic [TIME_BITS-1:0]   prev_time_i,
  input  logic [PERSON_BITS-1:0] prev_person_i,
  input  logic                   prev_kind_i,
  input  logic [TIME_BITS-1:0]   next_time_i,
  input  logic [PERSON_BITS-1:0] next_person_i,
  input  logic                   next_kind_i,
  output logic                   ge_o,
  output logic [TIME_BITS-1:0]   time_o,
  output logic [PERSON_BITS-1:0] person_o,
  output logic                   kind_o
);
  import sepq_pkg::*;

  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [PERSON_BITS-1:0] person_q, person_d;
  logic                   kind_q, kind_d;
  logic                   filled;

  // Slots past the fill count always count as "at or after" the new event,
  // which makes the flags along the chain a monotonic run of ones.
  assign filled = (count_i > CNT_BITS'(IDX));
  assign ge_o   = filled ? (time_q >= new_time_i) : 1'b1;

  always_comb begin
    time_d   = time_q;
    person_d = person_q;
    kind_d   = kind_q;
    priority if (ctrl_i.push && ge_o && prev_ge_i) begin
      time_d   = prev_time_i;
      person_d = prev_person_i;
      kind_d   = prev_kind_i;
    end else if (ctrl_i.push && ge_o) begin
      time_d   = new_time_i;
      person_d = new_person_i;
      kind_d   = new_kind_i;
    end else if (ctrl_i.pop) begin
      time_d   = next_time_i;
      person_d = next_person_i;
      kind_d   = next_kind_i;
    end else begin
      time_d   = time_q;
      person_d = person_q;
      kind_d   = kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q   <= time_d;
    person_q <= person_d;
    kind_q   <= kind_d;
  end

  assign time_o   = time_q;
  assign person_o = person_q;
  assign kind_o   = kind_q;

endmodule

// ===== design/sorted_event_priority_queue.sv =====
// Top level of the sorted event priority queue built from a chain of cells.
//
//   channel  direction  beat contents
//   in_i     sink       action, ev_time, person, event_kind
//   out_o    source     status, is_empty, head_time, head_person, head_kind, occupancy
//
// Every cell compares its key with the new event at once and shifts by one
// slot, so a push or a pop completes at the clock edge that accepts it.
// The result is held in an output register; a new beat is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset clears the fill count and the output valid; slot contents are not reset.
module sorted_event_priority_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 16,
  parameter int PERSON_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sepq_in_if.sink   in_i,
  sepq_out_if.source out_o
);
  import sepq_pkg::*;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_BITS-1:0]    count_q, count_d;
  logic                   out_valid_q;
  status_e                status_q, status_d;
  logic                   accept;
  logic                   full, empty;
  cell_ctrl_t             ctrl;

  logic                   ge      [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   c_time  [QUEUE_DEPTH];
  logic [PERSON_BITS-1:0] c_person[QUEUE_DEPTH];
  logic                   c_kind  [QUEUE_DEPTH];

  assign full   = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  assign ctrl.push = accept && (in_i.action == ACT_PUSH) && !full;
  assign ctrl.pop  = accept && (in_i.action == ACT_POP) && !empty;

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      status_d = ST_DONE;
      priority if (in_i.action == ACT_PUSH && full) begin
        status_d = ST_FULL;
      end else if (in_i.action == ACT_POP && empty) begin
        status_d = ST_EMPTY;
      end else if (in_i.action == ACT_PUSH) begin
        count_d = count_q + CNT_BITS'(1);
      end else begin
        count_d = count_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int PI = (i == 0) ? 0 : i - 1;
    localparam int NI = (i == QUEUE_DEPTH - 1) ? i : i + 1;
    logic prev_ge;
    assign prev_ge = (i == 0) ? 1'b0 : ge[PI];

    sepq_cell #(
      .IDX        (i),
      .TIME_BITS  (TIME_BITS),
      .PERSON_BITS(PERSON_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .new_time_i   (in_i.ev_time),
      .new_person_i (in_i.person),
      .new_kind_i   (in_i.event_kind),
      .prev_ge_i    (prev_ge),
      .prev_time_i  (c_time[PI]),
      .prev_person_i(c_person[PI]),
      .prev_kind_i  (c_kind[PI]),
      .next_time_i  (c_time[NI]),
      .next_person_i(c_person[NI]),
      .next_kind_i  (c_kind[NI]),
      .ge_o         (ge[i]),
      .time_o       (c_time[i]),
      .person_o     (c_person[i]),
      .kind_o       (c_kind[i])
    );
  end

  // The cells and the count only change on an accepted beat, so the head
  // read straight from slot zero stays stable while the result waits.
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.is_empty    = empty;
  assign out_o.head_time   = empty ? '0 : c_time[0];
  assign out_o.head_person = empty ? '0 : c_person[0];
  assign out_o.head_kind   = empty ? 1'b0 : c_kind[0];
  assign out_o.occupancy   = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> (count_q == $past(count_q) + CNT_BITS'(1)))
    else $error("push did not grow the queue");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.action == ACT_POP && empty) |=> (out_o.status == ST_EMPTY))
    else $error("pop on empty queue not flagged");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_BITS'(2)) |-> (c_time[0] <= c_time[1]))
    else $error("head entry is later than the second entry");

endmodule

// ===== test/tb_sorted_event_priority_queue.sv =====
// Self-checking testbench for the sorted event priority queue.
`timescale 1ns / 1ps

module tb_sorted_event_priority_queue;
  import sepq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int TIME_W      = 16;
  localparam int PERSON_W    = 14;
  localparam int CNT_W       = 7;
  localparam int DIR_ROWS    = 18;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 140;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  localparam logic KIND_TRANSMIT = 1'b0;
  localparam logic KIND_RECOVER  = 1'b1;

  typedef enum int {RX_FREE, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_e;

  typedef struct packed {
    status_e               status;
    logic                  is_empty;
    logic [TIME_W-1:0]     head_time;
    logic [PERSON_W-1:0]   head_person;
    logic                  head_kind;
    logic [CNT_W-1:0]      occupancy;
  } head_report_t;

  typedef struct packed {
    logic                  action;
    logic [TIME_W-1:0]     ev_time;
    logic [PERSON_W-1:0]   person;
    logic                  event_kind;
    logic                  typed;
    head_report_t          want;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sepq_in_if  #(.TIME_BITS(TIME_W), .PERSON_BITS(PERSON_W)) in_bus ();
  sepq_out_if #(.TIME_BITS(TIME_W), .PERSON_BITS(PERSON_W), .CNT_BITS(CNT_W)) out_bus ();

  sorted_event_priority_queue #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_BITS  (TIME_W),
    .PERSON_BITS(PERSON_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Predictor state: sorted slots with slot 0 as the earliest event.
  logic [TIME_W-1:0]   slot_time   [DEPTH];
  logic [PERSON_W-1:0] slot_person [DEPTH];
  logic                slot_kind   [DEPTH];
  int                  slot_count;

  head_report_t head_reports_q[$];
  beat_t        cur_beat;
  beat_t        dir_table [DIR_ROWS];
  int           error_count;
  int           cycle_count;
  int           burst_left;
  logic         hold_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic head_report_t sched_apply(input beat_t b);
    head_report_t r;
    int pos;
    r.status = ST_DONE;
    if (b.action == ACT_PUSH) begin
      if (slot_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Stop at the first entry with an equal or later time, so ties leave LIFO.
        pos = 0;
        while (pos < slot_count && slot_time[pos] < b.ev_time) pos++;
        for (int i = slot_count; i > pos; i--) begin
          slot_time[i]   = slot_time[i-1];
          slot_person[i] = slot_person[i-1];
          slot_kind[i]   = slot_kind[i-1];
        end
        slot_time[pos]   = b.ev_time;
        slot_person[pos] = b.person;
        slot_kind[pos]   = b.event_kind;
        slot_count++;
      end
    end else if (slot_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      for (int i = 1; i < slot_count; i++) begin
        slot_time[i-1]   = slot_time[i];
        slot_person[i-1] = slot_person[i];
        slot_kind[i-1]   = slot_kind[i];
      end
      slot_count--;
    end
    if (slot_count == 0) begin
      r.is_empty    = 1'b1;
      r.head_time   = '0;
      r.head_person = '0;
      r.head_kind   = 1'b0;
    end else begin
      r.is_empty    = 1'b0;
      r.head_time   = slot_time[0];
      r.head_person = slot_person[0];
      r.head_kind   = slot_kind[0];
    end
    r.occupancy = CNT_W'(slot_count);
    return r;
  endfunction

  function automatic beat_t mk_row(input logic act, input logic [TIME_W-1:0] t,
                                   input logic [PERSON_W-1:0] p, input logic k,
                                   input logic typed, input status_e st, input logic emp,
                                   input logic [TIME_W-1:0] ht,
                                   input logic [PERSON_W-1:0] hp, input logic hk,
                                   input logic [CNT_W-1:0] occ);
    beat_t b;
    b.action           = act;
    b.ev_time          = t;
    b.person           = p;
    b.event_kind       = k;
    b.typed            = typed;
    b.want.status      = st;
    b.want.is_empty    = emp;
    b.want.head_time   = ht;
    b.want.head_person = hp;
    b.want.head_kind   = hk;
    b.want.occupancy   = occ;
    return b;
  endfunction

  function automatic beat_t rand_beat(input int push_pct);
    beat_t b;
    b = '0;
    b.action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
    case ($urandom_range(0, 3))
      0:       b.ev_time = TIME_W'($urandom_range(0, 7));
      1:       b.ev_time = TIME_W'($urandom);
      2:       b.ev_time = $urandom_range(0, 1) ? '1 : '0;
      default: b.ev_time = {{(TIME_W-3){1'b1}}, 3'($urandom_range(0, 7))};
    endcase
    if ($urandom_range(0, 7) == 0) b.person = $urandom_range(0, 1) ? '1 : '0;
    else b.person = PERSON_W'($urandom);
    b.event_kind = $urandom_range(0, 1) ? KIND_RECOVER : KIND_TRANSMIT;
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_bus.valid      = 1'b0;
        in_bus.action     = 1'($urandom);
        in_bus.ev_time    = TIME_W'($urandom);
        in_bus.person     = PERSON_W'($urandom);
        in_bus.event_kind = 1'($urandom);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    cur_beat          = b;
    in_bus.valid      = 1'b1;
    in_bus.action     = b.action;
    in_bus.ev_time    = b.ev_time;
    in_bus.person     = b.person;
    in_bus.event_kind = b.event_kind;
    do @(posedge clk_i); while (!in_bus.ready);
    burst_left--;
  endtask

  // Hold the sender back until every outstanding result has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (head_reports_q.size() != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic note_mismatch(input string what, input head_report_t want,
                               input head_report_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("MISMATCH %s: exp %0d/%0d/%h/%h/%0d/%0d got %0d/%0d/%h/%h/%0d/%0d",
               what, want.status, want.is_empty, want.head_time, want.head_person,
               want.head_kind, want.occupancy, got.status, got.is_empty, got.head_time,
               got.head_person, got.head_kind, got.occupancy);
  endtask

  always @(posedge clk_i) begin : monitor
    head_report_t got;
    head_report_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got.status      = status_e'(out_bus.status);
        got.is_empty    = out_bus.is_empty;
        got.head_time   = out_bus.head_time;
        got.head_person = out_bus.head_person;
        got.head_kind   = out_bus.head_kind;
        got.occupancy   = out_bus.occupancy;
        if (head_reports_q.size() == 0) begin
          note_mismatch("unexpected beat", '0, got);
        end else begin
          want = head_reports_q.pop_front();
          if (got !== want) note_mismatch("wrong field", want, got);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        want = sched_apply(cur_beat);
        head_reports_q.push_back(cur_beat.typed ? cur_beat.want : want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver
    rx_mode_e mode;
    int seg_left;
    int hold_left;
    out_bus.ready = 1'b0;
    mode      = RX_FREE;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (mode)
          RX_FREE:     out_bus.ready = 1'b1;
          RX_COIN:     out_bus.ready = 1'($urandom_range(0, 1));
          RX_PERIODIC: out_bus.ready = (seg_left % 4 == 0);
          default:     out_bus.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int push_pct [PHASES];
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_PUSH;
    in_bus.ev_time    = '0;
    in_bus.person     = '0;
    in_bus.event_kind = KIND_TRANSMIT;
    cur_beat          = '0;
    slot_count        = 0;
    error_count       = 0;
    cycle_count       = 0;
    burst_left        = 0;
    hold_req          = 1'b0;
    push_pct          = '{50, 85, 90, 15, 55, 95, 10, 60};

    // Pop on empty, extremes of every field, a tie on time, then drain and refill.
    dir_table[0]  = mk_row(ACT_POP,  16'h0000, 14'h0000, KIND_TRANSMIT,
                           1'b1, ST_EMPTY, 1'b1, 16'h0000, 14'h0000, 1'b0, 7'd0);
    dir_table[1]  = mk_row(ACT_PUSH, 16'hFFFF, 14'h3FFF, KIND_RECOVER,
                           1'b1, ST_DONE, 1'b0, 16'hFFFF, 14'h3FFF, 1'b1, 7'd1);
    dir_table[2]  = mk_row(ACT_PUSH, 16'h0000, 14'h0000, KIND_TRANSMIT,
                           1'b1, ST_DONE, 1'b0, 16'h0000, 14'h0000, 1'b0, 7'd2);
    dir_table[3]  = mk_row(ACT_PUSH, 16'h0000, 14'h0005, KIND_RECOVER,
                           1'b1, ST_DONE, 1'b0, 16'h0000, 14'h0005, 1'b1, 7'd3);
    dir_table[4]  = mk_row(ACT_PUSH, 16'h0064, 14'h2AAA, KIND_TRANSMIT,
                           1'b0, ST_DONE, 1'b0, '0, '0, 1'b0, '0);
    dir_table[5]  = mk_row(ACT_PUSH, 16'h5555, 14'h1555, KIND_RECOVER,
                           1'b0, ST_DONE, 1'b0, '0, '0, 1'b0, '0);
    dir_table[6]  = mk_row(ACT_PUSH, 16'hFFFF, 14'h0000, KIND_TRANSMIT,
                           1'b0, ST_DONE, 1'b0, '0, '0, 1'b0, '0);
    dir_table[7]  = mk_row(ACT_PUSH, 16'h0001, 14'h3FFF, KIND_TRANSMIT,
                           1'b0, ST_DONE, 1'b0, '0, '0, 1'b0, '0);
    for (int r = 8; r < 14; r++)
      dir_table[r] = mk_row(ACT_POP, 16'h0000, 14'h0000, KIND_TRANSMIT,
                            1'b0, ST_DONE, 1'b0, '0, '0, 1'b0, '0);
    // The next two pops carry a full payload that the block has to ignore.
    dir_table[14] = mk_row(ACT_POP,  16'hFFFF, 14'h3FFF, KIND_RECOVER,
                           1'b1, ST_DONE, 1'b1, 16'h0000, 14'h0000, 1'b0, 7'd0);
    dir_table[15] = mk_row(ACT_POP,  16'hFFFF, 14'h3FFF, KIND_RECOVER,
                           1'b1, ST_EMPTY, 1'b1, 16'h0000, 14'h0000, 1'b0, 7'd0);
    dir_table[16] = mk_row(ACT_PUSH, 16'h0007, 14'h0001, KIND_TRANSMIT,
                           1'b1, ST_DONE, 1'b0, 16'h0007, 14'h0001, 1'b0, 7'd1);
    dir_table[17] = mk_row(ACT_POP,  16'h0000, 14'h0000, KIND_TRANSMIT,
                           1'b1, ST_DONE, 1'b1, 16'h0000, 14'h0000, 1'b0, 7'd0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) send_beat(dir_table[r]);
    wait_drained();

    // Push-heavy phases fill the queue to the top, pop-heavy ones drain it past empty.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1 || ph == 5) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(rand_beat(push_pct[ph]));
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (head_reports_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
